/* src/spdc_pkg.sv */
// ----------------------------------------------------------------------------
// spdc_pkg
// Shared types and constants for the scheduled pressure deadband controller.
// ----------------------------------------------------------------------------
package spdc_pkg;

   localparam int SLOTS_DEFAULT = 8;

   localparam logic [15:0] INVALID_FIELD = 16'hffff;

   // 4 mA in 1/256 mA units; (mA - 4) / 16 * 200 == (c - 1024) * 25 / 512
   localparam logic [12:0] CUR_OFFSET = 13'd1024;
   localparam logic [17:0] PRES_GAIN  = 18'd25;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   localparam logic [2:0] WDAY_NONE = 3'd0;
   localparam logic [2:0] WDAY_SUN  = 3'd1;
   localparam logic [2:0] WDAY_SAT  = 3'd7;

   localparam logic CSR_AUTO_MODE = 1'b0;
   localparam logic CSR_TOLERANCE = 1'b1;

   localparam logic       AUTO_MODE_RESET = 1'b1;
   localparam logic [9:0] TOLERANCE_RESET = 10'd10;

   localparam logic signed [1:0] DIR_RAISE = 2'sb01;
   localparam logic signed [1:0] DIR_HOLD  = 2'sb00;
   localparam logic signed [1:0] DIR_LOWER = 2'sb11;

   typedef struct packed {
      logic        req_type;
      logic        entry_bank;
      logic [2:0]  entry_slot;
      logic [15:0] entry_start;
      logic [15:0] entry_end;
      logic [15:0] entry_setpoint;
      logic [2:0]  weekday;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [12:0] outlet_current;
   } req_word_type;

   typedef struct packed {
      logic signed [1:0] direction;
      logic              matched;
      logic [2:0]        matched_slot;
      logic [15:0]       active_setpoint;
      logic [8:0]        outlet_pressure;
   } rsp_word_type;

   typedef struct packed {
      logic [15:0] start;
      logic [15:0] stop;
      logic [15:0] setpoint;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

/* src/scheduled_pressure_deadband_control_top.sv */
// ----------------------------------------------------------------------------
// scheduled_pressure_deadband_control_top
// Schedule table of pressure setpoints (weekday and weekend banks) and a
// deadband valve direction computed on each control tick.
// ----------------------------------------------------------------------------
// Load words: taken every cycle while idle, written to the table RAM at acceptance.
// Tick words: one RAM entry checked per cycle; in manual mode or on weekday 0 the
//   tick skips the scan, else entries are scanned from slot 0 to a hit or the last
//   slot; result registered when the output is free, then the next word is taken.
// Synchronous reset clears entry valid bits at once (no clearing pass),
//   auto_mode to 1 and tolerance to 10.
// ----------------------------------------------------------------------------
module scheduled_pressure_deadband_control_top #(
   parameter int SLOTS = spdc_pkg::SLOTS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  spdc_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output spdc_pkg::rsp_word_type rsp_word,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_index,
   input  logic [9:0]            csr_wdata
);

   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int ADDR_W = SLOT_W + 1;
   localparam int DEPTH  = 2 ** ADDR_W;
   localparam int EXT_W  = SLOT_W + 3;

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_RESULT} state_type;

   state_type           state_ff;
   logic [DEPTH-1:0]    valid_ff;
   logic                vld_rd_ff;
   logic                auto_mode_ff;
   logic [9:0]          tol_ff;
   logic                bank_ff;
   logic [SLOT_W-1:0]   idx_ff;
   logic [15:0]         now_ff;
   logic [8:0]          pres_ff;
   logic                hit_ff;
   logic [2:0]          slot_ff;
   logic [15:0]         set_ff;
   logic                rsp_valid_ff;
   spdc_pkg::rsp_word_type rsp_ff;

   logic                req_accept;
   logic                slot_ok;
   logic [EXT_W-1:0]    load_slot_ext;
   logic [EXT_W-1:0]    idx_ext;
   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic [ADDR_W-1:0]   rd_addr;
   logic [SLOT_W-1:0]   idx_nxt;
   logic [spdc_pkg::ENTRY_W-1:0] rd_data;
   spdc_pkg::entry_type wr_entry;
   spdc_pkg::entry_type rd_entry;
   logic                tick_bank;
   logic                tick_run;
   logic [12:0]         cur_diff;
   logic [17:0]         pres_prod;
   logic [8:0]          pres_in;
   logic                entry_hit;
   logic [16:0]         lo_sum;
   logic [16:0]         hi_sum;
   logic signed [1:0]   dir_in;
   logic                rsp_free;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_word   = rsp_ff;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   // table write on load
   assign load_slot_ext = EXT_W'(req_word.entry_slot);
   assign slot_ok       = (load_slot_ext < EXT_W'(SLOTS));
   assign wr_en         = req_accept && (req_word.req_type == spdc_pkg::REQ_LOAD) && slot_ok;
   assign wr_addr       = {req_word.entry_bank, load_slot_ext[SLOT_W-1:0]};
   assign wr_entry      = '{start:    req_word.entry_start,
                            stop:     req_word.entry_end,
                            setpoint: req_word.entry_setpoint};

   // tick setup
   assign tick_bank = (req_word.weekday == spdc_pkg::WDAY_SUN) ||
                      (req_word.weekday == spdc_pkg::WDAY_SAT);
   assign tick_run  = auto_mode_ff && (req_word.weekday != spdc_pkg::WDAY_NONE);
   assign cur_diff  = req_word.outlet_current - spdc_pkg::CUR_OFFSET;
   assign pres_prod = 18'(cur_diff) * spdc_pkg::PRES_GAIN;
   assign pres_in   = (req_word.outlet_current < spdc_pkg::CUR_OFFSET) ? 9'd0 : pres_prod[17:9];

   // scan
   assign idx_nxt  = idx_ff + SLOT_W'(1);
   assign idx_ext  = EXT_W'(idx_ff);
   assign rd_addr  = (state_ff == ST_IDLE) ? {tick_bank, {SLOT_W{1'b0}}} : {bank_ff, idx_nxt};
   assign rd_entry = spdc_pkg::entry_type'(rd_data);
   assign entry_hit = vld_rd_ff &&
                      (rd_entry.start    != spdc_pkg::INVALID_FIELD) &&
                      (rd_entry.stop     != spdc_pkg::INVALID_FIELD) &&
                      (rd_entry.setpoint != spdc_pkg::INVALID_FIELD) &&
                      (now_ff >= rd_entry.start) && (now_ff <= rd_entry.stop);

   // deadband
   assign lo_sum = 17'(pres_ff) + 17'(tol_ff);
   assign hi_sum = 17'(set_ff) + 17'(tol_ff);

   always_comb begin
      if (!hit_ff) begin
         dir_in = spdc_pkg::DIR_HOLD;
      end else if (lo_sum < 17'(set_ff)) begin
         dir_in = spdc_pkg::DIR_RAISE;
      end else if (17'(pres_ff) > hi_sum) begin
         dir_in = spdc_pkg::DIR_LOWER;
      end else begin
         dir_in = spdc_pkg::DIR_HOLD;
      end
   end

   spdc_ram #(
      .WIDTH (spdc_pkg::ENTRY_W),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         vld_rd_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         auto_mode_ff <= spdc_pkg::AUTO_MODE_RESET;
         tol_ff       <= spdc_pkg::TOLERANCE_RESET;
      end else begin
         vld_rd_ff <= valid_ff[rd_addr];
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               spdc_pkg::CSR_AUTO_MODE: auto_mode_ff <= csr_wdata[0];
               spdc_pkg::CSR_TOLERANCE: tol_ff       <= csr_wdata;
               default: ;
            endcase
         end
         if ((state_ff == ST_RESULT) && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_accept && (req_word.req_type == spdc_pkg::REQ_TICK)) begin
                  pres_ff <= pres_in;
                  now_ff  <= {3'b000, req_word.hour, 2'b00, req_word.minute};
                  bank_ff <= tick_bank;
                  idx_ff  <= '0;
                  hit_ff  <= 1'b0;
                  slot_ff <= 3'd0;
                  set_ff  <= 16'd0;
                  state_ff <= tick_run ? ST_SCAN : ST_RESULT;
               end
            end
            ST_SCAN: begin
               if (entry_hit) begin
                  hit_ff   <= 1'b1;
                  slot_ff  <= idx_ext[2:0];
                  set_ff   <= rd_entry.setpoint;
                  state_ff <= ST_RESULT;
               end else if (idx_ff == SLOT_W'(SLOTS - 1)) begin
                  state_ff <= ST_RESULT;
               end else begin
                  idx_ff <= idx_nxt;
               end
            end
            ST_RESULT: begin
               if (rsp_free) begin
                  rsp_ff.direction       <= dir_in;
                  rsp_ff.matched         <= hit_ff;
                  rsp_ff.matched_slot    <= slot_ff;
                  rsp_ff.active_setpoint <= set_ff;
                  rsp_ff.outlet_pressure <= pres_ff;
                  state_ff               <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   a_rsp_from_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESULT))
      else $error("result word raised outside result state");

   a_nomatch_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.matched |->
         rsp_ff.active_setpoint == 16'd0 && rsp_ff.matched_slot == 3'd0 &&
         rsp_ff.direction == spdc_pkg::DIR_HOLD)
      else $error("unmatched result carries setpoint, slot or direction");

   a_match_valid_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.matched |-> rsp_ff.active_setpoint != spdc_pkg::INVALID_FIELD)
      else $error("matched entry has invalid setpoint");

   a_load_marks_valid: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> valid_ff[$past(wr_addr)])
      else $error("loaded entry not marked valid");

   a_scan_no_accept: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |=> state_ff != ST_IDLE || $past(state_ff) != ST_SCAN)
      else $error("scan left without result");

endmodule

/* src/spdc_ram.sv */
// ----------------------------------------------------------------------------
// spdc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module spdc_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
